[sv/utt_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [15:0] UnitRepl      = 16'hFFFD;
  localparam logic [20:0] SuppBase      = 21'h010000;
  localparam logic [5:0]  HiSurrPrefix  = 6'b110110;
  localparam logic [5:0]  LoSurrPrefix  = 6'b110111;

  // One decoded job handed from the front to the back end.
  typedef struct packed {
    logic        has_repl;  // emit FFFD first
    logic        has_main;  // emit the code point after any FFFD
    logic [20:0] cp;
    logic        eos;       // the main unit terminates the string
  } job_t;

endpackage

[sv/utt_front.sv]
// Front end: accepts UTF-8 bytes, tracks the pending sequence and builds jobs.
module utt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output utt_pkg::job_t job_o
);
  import utt_pkg::*;

  typedef enum logic [2:0] {
    ClsAscii   = 3'd0,
    ClsCont    = 3'd1,
    ClsLead2   = 3'd2,
    ClsLead3   = 3'd3,
    ClsLead4   = 3'd4,
    ClsInvalid = 3'd5
  } byte_class_e;

  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;
  byte_class_e cls;
  logic        accept;
  logic        want_push;
  job_t        job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (!in_byte_i[7]) begin
      cls = ClsAscii;
    end else if (in_byte_i[7:6] == 2'b10) begin
      cls = ClsCont;
    end else if (in_byte_i[7:5] == 3'b110) begin
      cls = ClsLead2;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      cls = ClsLead3;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      cls = ClsLead4;
    end else begin
      cls = ClsInvalid;
    end
  end

  always_comb begin
    pend_d    = pend_q;
    part_d    = part_q;
    job       = '0;
    want_push = 1'b0;
    case (cls)
      ClsAscii: begin
        job.has_repl = (pend_q != 2'd0);
        job.has_main = 1'b1;
        job.cp       = {13'd0, in_byte_i};
        job.eos      = (in_byte_i == 8'd0);
        want_push    = 1'b1;
        pend_d       = 2'd0;
        if (in_byte_i == 8'd0) begin
          part_d = '0;
        end
      end
      ClsCont: begin
        if (pend_q == 2'd0) begin
          job.has_repl = 1'b1;
          want_push    = 1'b1;
        end else begin
          part_d = {part_q[14:0], in_byte_i[5:0]};
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            job.has_main = 1'b1;
            job.cp       = part_d;
            want_push    = 1'b1;
          end
        end
      end
      ClsLead2: begin
        job.has_repl = (pend_q != 2'd0);
        want_push    = job.has_repl;
        part_d       = {16'd0, in_byte_i[4:0]};
        pend_d       = 2'd1;
      end
      ClsLead3: begin
        job.has_repl = (pend_q != 2'd0);
        want_push    = job.has_repl;
        part_d       = {17'd0, in_byte_i[3:0]};
        pend_d       = 2'd2;
      end
      ClsLead4: begin
        job.has_repl = (pend_q != 2'd0);
        want_push    = job.has_repl;
        part_d       = {18'd0, in_byte_i[2:0]};
        pend_d       = 2'd3;
      end
      default: begin
        job.has_repl = 1'b1;
        want_push    = 1'b1;
        pend_d       = 2'd0;
      end
    endcase
  end

  assign push_o = accept && want_push;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

[sv/utt_queue.sv]
// Small job queue between the front end and the back end.
module utt_queue #(
  parameter int unsigned Depth = utt_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utt_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output utt_pkg::job_t head_o
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/utt_back.sv]
// Back end: expands each job into one or two UTF-16 units in an output register.
module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  utt_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   code_unit_o,
  output logic          end_of_string_o,
  output logic          last_of_item_o
);
  import utt_pkg::*;

  logic        sub_q, sub_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] unit_q, unit_d;
  logic        eos_q, eos_d;
  logic        last_q, last_d;
  logic        load;
  logic        big;
  logic        two_units;
  logic [20:0] offset;
  logic [15:0] hi_surr, lo_surr;

  assign big       = (head_i.cp[20:16] != 5'd0);
  assign offset    = head_i.cp - SuppBase;
  assign hi_surr   = {HiSurrPrefix, offset[19:10]};
  assign lo_surr   = {LoSurrPrefix, offset[9:0]};
  assign two_units = (head_i.has_repl && head_i.has_main) || (head_i.has_main && big);

  // A new unit enters the output register when a job is at the queue head and the register is empty or being drained.
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last_d;

  always_comb begin
    if (!sub_q) begin
      unit_d = head_i.has_repl ? UnitRepl : (big ? hi_surr : head_i.cp[15:0]);
    end else begin
      unit_d = head_i.has_repl ? head_i.cp[15:0] : lo_surr;
    end
    last_d = sub_q || !two_units;
    eos_d  = head_i.eos && last_d;
    sub_d  = load ? !last_d : sub_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= unit_d;
      eos_q  <= eos_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = unit_q;
  assign end_of_string_o = eos_q;
  assign last_of_item_o  = last_q;

endmodule

[sv/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   Channel | Signals                                   | Carries
//   --------+-------------------------------------------+---------------------------
//   in      | in_valid_i, in_ready_o, in_byte_i         | one UTF-8 byte
//   out     | out_valid_o, out_ready_i, code_unit_o,    | one UTF-16 code unit
//           | end_of_string_o, last_of_item_o           |
//
// A byte is taken every cycle while the job queue has room; bytes that give
// no unit still pass through the front end and only update its decoder state.
// Each byte gives 0, 1 or 2 units; the back end writes one unit per cycle to the
// output register unless the output stalls; a two-unit byte keeps its job at
// the queue head until both units are loaded into the registered output.
// Reset clears the decoder state, the queue and the output valid flag.
// A stall on the output fills the queue and then holds in_ready_o low.
module utf8_to_utf16_transcoder #(
  parameter int unsigned QueueDepth = utt_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        end_of_string_o,
  output logic        last_of_item_o
);
  import utt_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  utt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  utt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_unit_o     (code_unit_o),
    .end_of_string_o (end_of_string_o),
    .last_of_item_o  (last_of_item_o)
  );

endmodule

[sv/utt_checker.sv]
// Port-level checks for the transcoder, bound to the top level.
module utt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] code_unit_o,
  input logic        end_of_string_o,
  input logic        last_of_item_o
);

  // A stalled unit stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before the transaction completed");

  // A stalled unit keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(code_unit_o) && $stable(end_of_string_o)
      && $stable(last_of_item_o))
    else $error("output payload changed while stalled");

  // The terminator is a zero unit and always closes its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> code_unit_o == 16'h0000 && last_of_item_o)
    else $error("end_of_string_o on a unit that is not a final zero");

  // The second unit of a byte follows directly after the first is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=> out_valid_o)
    else $error("second unit of a byte did not follow");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_utt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .code_unit_o     (code_unit_o),
  .end_of_string_o (end_of_string_o),
  .last_of_item_o  (last_of_item_o)
);

[tb/sv/tb.sv]
// Testbench for the UTF-8 to UTF-16 transcoder: random and directed byte streams, scoreboarded.
module tb;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned PhaseBytes    = 340;
  localparam int unsigned MaxReported   = 10;

  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
    logic        last;
  } utf16_unit_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [15:0] code_unit_o;
  logic        end_of_string_o;
  logic        last_of_item_o;

  // Decoder state mirrored by the predictor.
  logic [1:0]  cont_left = '0;
  logic [20:0] cp_acc    = '0;

  logic [7:0]  byte_backlog [$];
  utf16_unit_t units_due [$];
  utf16_unit_t want_unit;
  utf16_unit_t got_unit;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatches     = 0;
  logic        in_fire        = 1'b0;

  utf8_to_utf16_transcoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .end_of_string_o(end_of_string_o),
    .last_of_item_o (last_of_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Works out the code units that one accepted byte gives and queues them.
  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] u [2];
    logic        e [2];
    int          n;
    logic [20:0] offs;
    n = 0;
    casez (b)
      8'b0???????: begin
        if (cont_left != 2'd0) begin
          u[n] = utt_pkg::UnitRepl; e[n] = 1'b0; n++;
        end
        u[n] = {8'h00, b}; e[n] = (b == 8'h00); n++;
        cont_left = 2'd0;
        if (b == 8'h00) cp_acc = '0;
      end
      8'b10??????: begin
        if (cont_left == 2'd0) begin
          u[n] = utt_pkg::UnitRepl; e[n] = 1'b0; n++;
        end else begin
          cp_acc    = {cp_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            if (cp_acc < utt_pkg::SuppBase) begin
              u[n] = cp_acc[15:0]; e[n] = 1'b0; n++;
            end else begin
              // Supplementary plane: split the 20-bit offset into a surrogate pair.
              offs = cp_acc - utt_pkg::SuppBase;
              u[n] = {utt_pkg::HiSurrPrefix, offs[19:10]}; e[n] = 1'b0; n++;
              u[n] = {utt_pkg::LoSurrPrefix, offs[9:0]};   e[n] = 1'b0; n++;
            end
          end
        end
      end
      8'b110?????, 8'b1110????, 8'b11110???: begin
        if (cont_left != 2'd0) begin
          u[n] = utt_pkg::UnitRepl; e[n] = 1'b0; n++;
        end
        if (b[5] == 1'b0) begin
          cp_acc = {16'd0, b[4:0]}; cont_left = 2'd1;
        end else if (b[4] == 1'b0) begin
          cp_acc = {17'd0, b[3:0]}; cont_left = 2'd2;
        end else begin
          cp_acc = {18'd0, b[2:0]}; cont_left = 2'd3;
        end
      end
      default: begin
        u[n] = utt_pkg::UnitRepl; e[n] = 1'b0; n++;
        cont_left = 2'd0;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      units_due.push_back('{unit: u[i], eos: e[i], last: (i == n - 1)});
    end
  endtask

  // Mostly well-formed characters with random payload, plus terminators,
  // truncated sequences and arbitrary bytes.
  task automatic queue_random_bytes(input int unsigned count);
    int unsigned added;
    int unsigned sel;
    int unsigned len;
    int unsigned conts;
    logic [7:0]  r;
    added = 0;
    while (added < count) begin
      sel = $urandom_range(99);
      r   = 8'($urandom);
      if (sel < 8) begin
        byte_backlog.push_back(8'h00);
        added++;
      end else if (sel < 82) begin
        len = $urandom_range(1, 4);
        if (sel >= 70 && len > 1) conts = $urandom_range(0, len - 2);
        else conts = len - 1;
        case (len)
          1: byte_backlog.push_back(8'($urandom_range(1, 127)));
          2: byte_backlog.push_back({3'b110, r[4:0]});
          3: byte_backlog.push_back({4'b1110, r[3:0]});
          default: byte_backlog.push_back({5'b11110, r[2:0]});
        endcase
        added++;
        for (int i = 0; i < conts; i++) begin
          r = 8'($urandom);
          byte_backlog.push_back({2'b10, r[5:0]});
          added++;
        end
      end else begin
        byte_backlog.push_back(r);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid_i || units_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: a transaction stays offered until it is taken.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (byte_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= byte_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks outputs first, so a unit can never match an expectation from the same edge.
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_unit = '{unit: code_unit_o, eos: end_of_string_o, last: last_of_item_o};
        if (units_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("Unexpected unit: got unit=%h eos=%b last=%b",
                     got_unit.unit, got_unit.eos, got_unit.last);
          end
        end else begin
          want_unit = units_due.pop_front();
          if (got_unit !== want_unit) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
              $display("Unit mismatch: expected unit=%h eos=%b last=%b, got unit=%h eos=%b last=%b",
                       want_unit.unit, want_unit.eos, want_unit.last,
                       got_unit.unit, got_unit.eos, got_unit.last);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_byte(in_byte_i);

      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else if (byte_backlog.size() != 0 || in_valid_i || units_due.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every sequence length, and each malformed case.
    byte_backlog = '{8'h41, 8'h7F, 8'h00,
                     8'hC3, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'h80,
                     8'hE2, 8'h41,
                     8'hC3, 8'hF0, 8'h9F, 8'h00,
                     8'hF8,
                     8'hC0, 8'h80,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hFF};
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 78; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 78; end
        default: begin send_gap_pct = 38; recv_stall_pct = 38; end
      endcase
      // The long hold-off fills the block while the sender keeps offering.
      if (phase == 0) hold_reqs++;
      queue_random_bytes(PhaseBytes);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (units_due.size() != 0) begin
      mismatches++;
      $display("%0d expected units never arrived", units_due.size());
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[utf8_to_utf16_transcoder.f]
sv/utt_pkg.sv
sv/utt_front.sv
sv/utt_queue.sv
sv/utt_back.sv
sv/utf8_to_utf16_transcoder.sv
sv/utt_checker.sv
tb/sv/tb.sv
